>>> rtl/ticp_pkg.sv
// Shared types and constants for the TCP irregular chain parser.
// No dependencies; imported by ticp_seek and tcp_irregular_chain_parser.
`default_nettype none

package ticp_pkg;

    localparam int MAX_IP_HEADERS = 4;
    localparam int HDR_W          = 2;
    localparam int CNT_W          = 3;
    localparam int MASK_W         = 4;
    localparam int LEN_W          = 5;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        FK_IP_ID     = 3'd0,
        FK_DSCP_ECN  = 3'd1,
        FK_TTL       = 3'd2,
        FK_TCP_FLAGS = 3'd3,
        FK_CHECKSUM  = 3'd4,
        FK_TOO_SHORT = 3'd5
    } field_kind_t;

    typedef enum logic [1:0] {
        CFG_HEADER_COUNT = 2'd0,
        CFG_IPV4_MASK    = 2'd1,
        CFG_RANDOM_IPID  = 2'd2,
        CFG_ECN_DEFAULT  = 2'd3
    } cfg_index_t;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_IPID = 7'b0000010,
        PH_DSCP = 7'b0000100,
        PH_TTL  = 7'b0001000,
        PH_TCPF = 7'b0010000,
        PH_CSUM = 7'b0100000,
        PH_DONE = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [CNT_W-1:0]  start_hdr;
        logic [1:0]        start_sub;
        logic [CNT_W-1:0]  hdr_count;
        logic [MASK_W-1:0] ipv4_mask;
        logic [MASK_W-1:0] rnd_mask;
        logic              inner_random;
        logic              ecn_active;
        logic              ttl_active;
    } seek_req_t;

    typedef struct packed {
        phase_t            phase;
        logic [HDR_W-1:0]  hdr;
    } seek_rsp_t;

endpackage

`default_nettype wire

>>> rtl/ticp_seek.sv
// Next-field search: finds the next chain field present from a header/sub-step.
// Depends on ticp_pkg.
`default_nettype none

module ticp_seek
    import ticp_pkg::*;
(
    input  wire seek_req_t req,
    output seek_rsp_t      rsp
);

    logic              found;
    logic [CNT_W-1:0]  idx;
    logic [1:0]        sub;
    logic              inner;
    logic              rnd;

    always_comb begin
        found   = 1'b0;
        idx     = '0;
        sub     = '0;
        inner   = 1'b0;
        rnd     = 1'b0;
        rsp.phase = req.ecn_active ? PH_TCPF : PH_CSUM;
        rsp.hdr   = HDR_W'(req.hdr_count - CNT_W'(1));
        for (int i = 0; i < MAX_IP_HEADERS; i++) begin
            idx = CNT_W'(i);
            if (!found && idx >= req.start_hdr && idx < req.hdr_count) begin
                sub   = (idx == req.start_hdr) ? req.start_sub : 2'd0;
                inner = (idx == req.hdr_count - CNT_W'(1));
                rnd   = inner ? req.inner_random : req.rnd_mask[i];
                if (sub == 2'd0 && req.ipv4_mask[i] && rnd) begin
                    found     = 1'b1;
                    rsp.phase = PH_IPID;
                    rsp.hdr   = HDR_W'(i);
                end else if (sub <= 2'd1 && !inner && req.ecn_active) begin
                    found     = 1'b1;
                    rsp.phase = PH_DSCP;
                    rsp.hdr   = HDR_W'(i);
                end else if (!inner && req.ttl_active) begin
                    found     = 1'b1;
                    rsp.phase = PH_TTL;
                    rsp.hdr   = HDR_W'(i);
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/tcp_irregular_chain_parser.sv
// TCP irregular chain parser top level: input register, chain state, result register.
// Depends on ticp_pkg and ticp_seek.
//
// Usage:
//   The s_ channel carries one transaction per chain event: a start (latches the
//   per-packet flags), a data byte, or an end of available data. The m_ channel
//   carries at most one field per input transaction: IP-ID, DSCP/ECN, TTL, TCP
//   flags, checksum (last=1) or a too-short error (last=1). Start, unused bytes
//   and the first byte of a 16-bit field give no result.
//   Throughput: one input transaction per cycle while the receiver does not stall.
//   Path: an accepted transaction passes the input register, then chain decode
//   into the result register, which drives m_valid.
//   When the receiver stalls, the result register holds and the input register
//   fills; s_ready drops only when both are occupied.
//   Configuration: cfg_wr_en writes register cfg_index at once; write only
//   while the block is idle.
//   Reset (aresetn low, synchronous) restores the configuration defaults,
//   empties both registers and returns the parser to idle.
`default_nettype none

module tcp_irregular_chain_parser
    import ticp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [3:0]        cfg_wdata,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_inner_random_ipid,
    input  wire logic              s_ecn_presence_known,
    input  wire logic              s_ecn_used_in_packet,
    input  wire logic              s_ttl_in_chain,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [2:0]             m_field_kind,
    output logic [1:0]             m_header_index,
    output logic [15:0]            m_field_value,
    output logic [1:0]             m_ecn_bits,
    output logic [3:0]             m_res_bits,
    output logic [4:0]             m_chain_length,
    output logic                   m_last
);

    // configuration
    logic [CNT_W-1:0]  header_count_reg;
    logic [MASK_W-1:0] ipv4_mask_reg;
    logic [MASK_W-1:0] rnd_mask_reg;
    logic              ecn_default_reg;

    // input register
    logic              in_valid_reg;
    logic [1:0]        in_opcode_reg;
    logic [7:0]        in_byte_reg;
    logic              in_inner_rnd_reg;
    logic              in_ecn_known_reg;
    logic              in_ecn_pkt_reg;
    logic              in_ttl_reg;

    // chain state
    phase_t            phase_reg, phase_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;
    logic              second_reg, second_next;
    logic [7:0]        hold_reg, hold_next;
    logic              ecn_reg, ecn_next;
    logic              ttl_reg, ttl_next;
    logic              inner_reg, inner_next;
    logic [LEN_W-1:0]  consumed_reg, consumed_next;

    // result register
    logic              m_valid_reg;
    field_kind_t       kind_reg, kind_next;
    logic [HDR_W-1:0]  out_hdr_reg, out_hdr_next;
    logic [15:0]       value_reg, value_next;
    logic [1:0]        out_ecn_reg, out_ecn_next;
    logic [3:0]        res_reg, res_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              last_reg, last_next;
    logic              emit;

    logic              out_free;
    logic              work;
    logic [CNT_W-1:0]  eff_count;
    logic              start_ecn;
    logic [LEN_W-1:0]  consumed_inc;
    seek_req_t         seek_req;
    seek_rsp_t         seek_rsp;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;
    assign work     = in_valid_reg && out_free;

    always_comb begin
        if (header_count_reg == '0) begin
            eff_count = CNT_W'(1);
        end else if (header_count_reg > CNT_W'(MAX_IP_HEADERS)) begin
            eff_count = CNT_W'(MAX_IP_HEADERS);
        end else begin
            eff_count = header_count_reg;
        end
    end

    assign start_ecn    = in_ecn_known_reg ? in_ecn_pkt_reg : ecn_default_reg;
    assign consumed_inc = (consumed_reg == '1) ? consumed_reg : consumed_reg + LEN_W'(1);

    always_comb begin
        seek_req.hdr_count    = eff_count;
        seek_req.ipv4_mask    = ipv4_mask_reg;
        seek_req.rnd_mask     = rnd_mask_reg;
        seek_req.start_hdr    = {1'b0, hdr_reg};
        seek_req.start_sub    = 2'd0;
        seek_req.inner_random = inner_reg;
        seek_req.ecn_active   = ecn_reg;
        seek_req.ttl_active   = ttl_reg;
        if (in_opcode_reg == OP_START) begin
            seek_req.start_hdr    = '0;
            seek_req.inner_random = in_inner_rnd_reg;
            seek_req.ecn_active   = start_ecn;
            seek_req.ttl_active   = in_ttl_reg;
        end else begin
            case (phase_reg)
                PH_IPID: seek_req.start_sub = 2'd1;
                PH_DSCP: seek_req.start_sub = 2'd2;
                PH_TTL:  seek_req.start_hdr = {1'b0, hdr_reg} + CNT_W'(1);
                default: seek_req.start_sub = 2'd0;
            endcase
        end
    end

    ticp_seek u_seek (
        .req (seek_req),
        .rsp (seek_rsp)
    );

    always_comb begin
        phase_next    = phase_reg;
        hdr_next      = hdr_reg;
        second_next   = second_reg;
        hold_next     = hold_reg;
        ecn_next      = ecn_reg;
        ttl_next      = ttl_reg;
        inner_next    = inner_reg;
        consumed_next = consumed_reg;
        emit          = 1'b0;
        kind_next     = kind_reg;
        out_hdr_next  = hdr_reg;
        value_next    = '0;
        out_ecn_next  = '0;
        res_next      = '0;
        len_next      = consumed_reg;
        last_next     = 1'b0;
        if (work) begin
            if (in_opcode_reg == OP_START) begin
                inner_next    = in_inner_rnd_reg;
                ecn_next      = start_ecn;
                ttl_next      = in_ttl_reg;
                consumed_next = '0;
                second_next   = 1'b0;
                hold_next     = '0;
                phase_next    = seek_rsp.phase;
                hdr_next      = seek_rsp.hdr;
            end else if (in_opcode_reg == OP_END && phase_reg != PH_IDLE
                         && phase_reg != PH_DONE) begin
                emit        = 1'b1;
                kind_next   = FK_TOO_SHORT;
                last_next   = 1'b1;
                phase_next  = PH_DONE;
                second_next = 1'b0;
            end else if (in_opcode_reg == OP_DATA && phase_reg != PH_IDLE
                         && phase_reg != PH_DONE) begin
                consumed_next = consumed_inc;
                len_next      = consumed_inc;
                case (phase_reg)
                    PH_IPID, PH_CSUM: begin
                        if (!second_reg) begin
                            second_next = 1'b1;
                            hold_next   = in_byte_reg;
                        end else begin
                            second_next = 1'b0;
                            emit        = 1'b1;
                            value_next  = {hold_reg, in_byte_reg};
                            if (phase_reg == PH_IPID) begin
                                kind_next  = FK_IP_ID;
                                phase_next = seek_rsp.phase;
                                hdr_next   = seek_rsp.hdr;
                            end else begin
                                kind_next  = FK_CHECKSUM;
                                last_next  = 1'b1;
                                phase_next = PH_DONE;
                            end
                        end
                    end
                    PH_DSCP: begin
                        emit         = 1'b1;
                        kind_next    = FK_DSCP_ECN;
                        value_next   = {10'd0, in_byte_reg[7:2]};
                        out_ecn_next = in_byte_reg[1:0];
                        phase_next   = seek_rsp.phase;
                        hdr_next     = seek_rsp.hdr;
                    end
                    PH_TTL: begin
                        emit       = 1'b1;
                        kind_next  = FK_TTL;
                        value_next = {8'd0, in_byte_reg};
                        phase_next = seek_rsp.phase;
                        hdr_next   = seek_rsp.hdr;
                    end
                    default: begin
                        emit         = 1'b1;
                        kind_next    = FK_TCP_FLAGS;
                        value_next   = {14'd0, in_byte_reg[1:0]};
                        out_ecn_next = in_byte_reg[7:6];
                        res_next     = in_byte_reg[5:2];
                        phase_next   = PH_CSUM;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg <= CNT_W'(1);
            ipv4_mask_reg    <= MASK_W'(1);
            rnd_mask_reg     <= '0;
            ecn_default_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HEADER_COUNT: header_count_reg <= cfg_wdata[CNT_W-1:0];
                CFG_IPV4_MASK:    ipv4_mask_reg    <= cfg_wdata[MASK_W-1:0];
                CFG_RANDOM_IPID:  rnd_mask_reg     <= cfg_wdata[MASK_W-1:0];
                default:          ecn_default_reg  <= cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg    <= s_opcode;
            in_byte_reg      <= s_data_byte;
            in_inner_rnd_reg <= s_inner_random_ipid;
            in_ecn_known_reg <= s_ecn_presence_known;
            in_ecn_pkt_reg   <= s_ecn_used_in_packet;
            in_ttl_reg       <= s_ttl_in_chain;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            hdr_reg      <= '0;
            second_reg   <= 1'b0;
            hold_reg     <= '0;
            ecn_reg      <= 1'b0;
            ttl_reg      <= 1'b0;
            inner_reg    <= 1'b0;
            consumed_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            hdr_reg      <= hdr_next;
            second_reg   <= second_next;
            hold_reg     <= hold_next;
            ecn_reg      <= ecn_next;
            ttl_reg      <= ttl_next;
            inner_reg    <= inner_next;
            consumed_reg <= consumed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg    <= kind_next;
            out_hdr_reg <= out_hdr_next;
            value_reg   <= value_next;
            out_ecn_reg <= out_ecn_next;
            res_reg     <= res_next;
            len_reg     <= len_next;
            last_reg    <= last_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_field_kind   = kind_reg;
    assign m_header_index = out_hdr_reg;
    assign m_field_value  = value_reg;
    assign m_ecn_bits     = out_ecn_reg;
    assign m_res_bits     = res_reg;
    assign m_chain_length = len_reg;
    assign m_last         = last_reg;

    a_last_ends_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last_next) |=> (phase_reg == PH_DONE))
        else $error("chain not closed after last field");

    a_second_byte_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> (phase_reg == PH_IPID || phase_reg == PH_CSUM))
        else $error("half word held outside a 16-bit field");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> in_valid_reg)
        else $error("stalled input transaction dropped");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !emit)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
